### sv/energy_meter_frame_receiver_macros.svh
// ---------------------------------------------------------------------------
// Energy meter frame receiver assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef ENERGY_METER_FRAME_RECEIVER_MACROS_SVH
`define ENERGY_METER_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define EMFR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EMFR_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define EMFR_ASSERT(lbl, clk, rstn, prop, msg)
`define EMFR_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

### sv/emfr_pkg.sv
// ---------------------------------------------------------------------------
// Energy meter frame receiver package
// Shared constants, register codes and the frame handoff record.
// ---------------------------------------------------------------------------
package emfr_pkg;

    localparam int DEFAULT_FRAME_LENGTH  = 24;
    localparam int DEFAULT_ADDRESS_SLOTS = 4;

    localparam int ADDR_REGS     = 4;
    localparam int FIELD_BYTES   = 15;
    localparam int FIELD_CNT_W   = 4;
    localparam int FIELD_BITS    = FIELD_BYTES * 8;
    localparam logic [7:0] CHECKSUM_SEED = 8'h55;

    typedef enum logic [2:0] {
        REG_ADDRESS_COUNT    = 3'd0,
        REG_DEVICE_ADDRESS_0 = 3'd1,
        REG_DEVICE_ADDRESS_1 = 3'd2,
        REG_DEVICE_ADDRESS_2 = 3'd3,
        REG_DEVICE_ADDRESS_3 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic       valid;
        logic       bank;
        logic [1:0] slot;
        logic       ok;
    } frame_done_t;

endpackage

### sv/energy_meter_frame_receiver.sv
// ---------------------------------------------------------------------------
// Energy meter frame receiver
// Address hunt, running checksum and frame capture over a meter byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel carries one received serial byte per beat (s_rx_byte).
//   Idle bytes are dropped until one equals an enabled device address; that
//   byte opens a frame of FRAME_LENGTH bytes. The last byte is the checksum.
//   m_ channel carries one beat per finished frame: slot, frame_ok and the
//   five 24-bit readings from bytes 1 to 15, big-endian.
//   Throughput: one byte per cycle while s_ready is high. Frames are written
//   into a two-bank memory; the finished bank is drained one byte per cycle
//   through the memory read port and the assembly register into the result
//   register. The next frame fills the other bank meanwhile.
//   s_ready drops only on the last byte of a frame while the previous frame
//   is still being drained or waiting to enter the result register.
//   A stalled m_ready holds the result register and, through the drain, the
//   input on the following frame's last byte.
//   Reset clears the register file, the byte position and the pipeline;
//   the frame memory needs no clearing.
//   Configuration: APB registers at 4*i; write only while idle.
// ---------------------------------------------------------------------------
module energy_meter_frame_receiver #(
    parameter int FRAME_LENGTH  = emfr_pkg::DEFAULT_FRAME_LENGTH,
    parameter int ADDRESS_SLOTS = emfr_pkg::DEFAULT_ADDRESS_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_slot,
    output logic               m_frame_ok,
    output logic [23:0]        m_voltage_raw,
    output logic signed [23:0] m_current_a_raw,
    output logic signed [23:0] m_current_b_raw,
    output logic signed [23:0] m_power_a_raw,
    output logic signed [23:0] m_power_b_raw
);

    localparam int PW = $clog2(FRAME_LENGTH);
    localparam int NR = emfr_pkg::ADDR_REGS;
    localparam int SLOT_LIMIT = (ADDRESS_SLOTS < NR) ? ADDRESS_SLOTS : NR;
    localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LENGTH - 1);

    logic [2:0]    address_count_reg;
    logic [7:0]    device_address_reg [NR];
    logic [PW-1:0] pos_reg;
    logic [7:0]    sum_reg;
    logic [1:0]    slot_reg;
    logic          bank_reg;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic [2:0]            count_eff;
    logic                  hit;
    logic [1:0]            hit_slot;
    logic                  accept;
    logic                  unload_busy;
    emfr_pkg::frame_done_t done;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_count_reg <= '0;
            for (int i = 0; i < NR; i++) begin
                device_address_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                emfr_pkg::REG_ADDRESS_COUNT:    address_count_reg     <= pwdata[2:0];
                emfr_pkg::REG_DEVICE_ADDRESS_0: device_address_reg[0] <= pwdata[7:0];
                emfr_pkg::REG_DEVICE_ADDRESS_1: device_address_reg[1] <= pwdata[7:0];
                emfr_pkg::REG_DEVICE_ADDRESS_2: device_address_reg[2] <= pwdata[7:0];
                emfr_pkg::REG_DEVICE_ADDRESS_3: device_address_reg[3] <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            emfr_pkg::REG_ADDRESS_COUNT:    prdata = {29'd0, address_count_reg};
            emfr_pkg::REG_DEVICE_ADDRESS_0: prdata = {24'd0, device_address_reg[0]};
            emfr_pkg::REG_DEVICE_ADDRESS_1: prdata = {24'd0, device_address_reg[1]};
            emfr_pkg::REG_DEVICE_ADDRESS_2: prdata = {24'd0, device_address_reg[2]};
            emfr_pkg::REG_DEVICE_ADDRESS_3: prdata = {24'd0, device_address_reg[3]};
            default:                        prdata = '0;
        endcase
    end

    assign count_eff = (address_count_reg > 3'(SLOT_LIMIT)) ? 3'(SLOT_LIMIT)
                                                            : address_count_reg;

    // lowest matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = NR - 1; i >= 0; i--) begin
            if ((3'(i) < count_eff) && (device_address_reg[i] == s_rx_byte)) begin
                hit      = 1'b1;
                hit_slot = 2'(i);
            end
        end
    end

    assign s_ready = !((pos_reg == LAST_POS) && unload_busy);
    assign accept  = s_valid && s_ready;

    assign done.valid = accept && (pos_reg == LAST_POS);
    assign done.bank  = bank_reg;
    assign done.slot  = slot_reg;
    assign done.ok    = ((~sum_reg) == s_rx_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            slot_reg <= '0;
            bank_reg <= 1'b0;
        end else if (accept) begin
            if (pos_reg == '0) begin
                if (hit) begin
                    pos_reg  <= PW'(1);
                    sum_reg  <= emfr_pkg::CHECKSUM_SEED + s_rx_byte;
                    slot_reg <= hit_slot;
                end
            end else if (pos_reg == LAST_POS) begin
                pos_reg  <= '0;
                bank_reg <= !bank_reg;
            end else begin
                pos_reg <= pos_reg + PW'(1);
                sum_reg <= sum_reg + s_rx_byte;
            end
        end
    end

    emfr_unload #(
        .FRAME_LENGTH(FRAME_LENGTH),
        .PW          (PW)
    ) u_unload (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .wr_en          (accept && ((pos_reg != '0) || hit)),
        .wr_bank        (bank_reg),
        .wr_pos         (pos_reg),
        .wr_data        (s_rx_byte),
        .done           (done),
        .busy           (unload_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_slot         (m_slot),
        .m_frame_ok     (m_frame_ok),
        .m_voltage_raw  (m_voltage_raw),
        .m_current_a_raw(m_current_a_raw),
        .m_current_b_raw(m_current_b_raw),
        .m_power_a_raw  (m_power_a_raw),
        .m_power_b_raw  (m_power_b_raw)
    );

endmodule

### sv/emfr_unload.sv
// ---------------------------------------------------------------------------
// Energy meter frame unload
// Double-banked frame memory; drains the reading bytes of a finished frame
// into the result register while the next frame fills the other bank.
// ---------------------------------------------------------------------------
`include "energy_meter_frame_receiver_macros.svh"

module emfr_unload #(
    parameter int FRAME_LENGTH = emfr_pkg::DEFAULT_FRAME_LENGTH,
    parameter int PW = $clog2(FRAME_LENGTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic                  wr_bank,
    input  logic [PW-1:0]         wr_pos,
    input  logic [7:0]            wr_data,
    input  emfr_pkg::frame_done_t done,
    output logic                  busy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_slot,
    output logic                  m_frame_ok,
    output logic [23:0]           m_voltage_raw,
    output logic signed [23:0]    m_current_a_raw,
    output logic signed [23:0]    m_current_b_raw,
    output logic signed [23:0]    m_power_a_raw,
    output logic signed [23:0]    m_power_b_raw
);

    localparam int DEPTH = 2 * FRAME_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = emfr_pkg::FIELD_CNT_W;
    localparam int FB    = emfr_pkg::FIELD_BITS;

    logic [7:0] mem [DEPTH];

    logic          busy_reg;
    logic          bank_reg;
    logic [1:0]    slot_reg;
    logic          ok_reg;
    logic [CW-1:0] rd_cnt_reg;
    logic [CW-1:0] sh_cnt_reg;
    logic          rd_vld_reg;
    logic [7:0]    rd_data_reg;
    logic [FB-1:0] asm_reg;
    logic          m_valid_reg;
    logic [1:0]    m_slot_reg;
    logic          m_ok_reg;
    logic [FB-1:0] m_data_reg;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_issue;
    logic          asm_full;
    logic          handoff;

    assign wr_addr  = AW'(wr_pos) + (wr_bank ? AW'(FRAME_LENGTH) : AW'(0));
    assign rd_addr  = AW'(rd_cnt_reg) + AW'(1) + (bank_reg ? AW'(FRAME_LENGTH) : AW'(0));
    assign rd_issue = busy_reg && (rd_cnt_reg != CW'(emfr_pkg::FIELD_BYTES));
    assign asm_full = busy_reg && (sh_cnt_reg == CW'(emfr_pkg::FIELD_BYTES));
    assign handoff  = asm_full && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            rd_cnt_reg  <= '0;
            sh_cnt_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= rd_issue;
            if (rd_issue) begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            if (rd_vld_reg) begin
                asm_reg    <= {asm_reg[FB-9:0], rd_data_reg};
                sh_cnt_reg <= sh_cnt_reg + CW'(1);
            end
            if (done.valid) begin
                busy_reg   <= 1'b1;
                bank_reg   <= done.bank;
                slot_reg   <= done.slot;
                ok_reg     <= done.ok;
                rd_cnt_reg <= '0;
                sh_cnt_reg <= '0;
            end else if (handoff) begin
                busy_reg <= 1'b0;
            end
            if (handoff) begin
                m_valid_reg <= 1'b1;
                m_slot_reg  <= slot_reg;
                m_ok_reg    <= ok_reg;
                m_data_reg  <= asm_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign busy            = busy_reg;
    assign m_valid         = m_valid_reg;
    assign m_slot          = m_slot_reg;
    assign m_frame_ok      = m_ok_reg;
    assign m_voltage_raw   = m_data_reg[FB-1 -: 24];
    assign m_current_a_raw = $signed(m_data_reg[FB-25 -: 24]);
    assign m_current_b_raw = $signed(m_data_reg[FB-49 -: 24]);
    assign m_power_a_raw   = $signed(m_data_reg[FB-73 -: 24]);
    assign m_power_b_raw   = $signed(m_data_reg[23:0]);

    `EMFR_NEVER(a_done_while_busy, aclk, aresetn, done.valid && busy_reg, "frame done while unload busy")
    `EMFR_ASSERT(a_read_in_unload, aclk, aresetn, rd_vld_reg |-> busy_reg, "read data outside unload")
    `EMFR_ASSERT(a_shift_behind_read, aclk, aresetn, busy_reg |-> (sh_cnt_reg <= rd_cnt_reg), "shift ahead of read")

endmodule

### test/tb_energy_meter_frame_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Energy meter frame receiver testbench
// Drives received bytes into the s_ channel and checks every result beat.
// Configuration goes in over APB.
// A scoreboard follows the address hunt, frame capture and checksum, and it
// predicts slot, frame_ok and the five readings of each finished frame.
// Directed frames cover the field extremes, bad checksums, slot priority,
// the clamped address count and a register change during a frame.
// Random traffic follows: mostly well-formed frames, with noise bytes and
// cut-off frames mixed in. It runs under three back-pressure mixes.
// ---------------------------------------------------------------------------
module tb_energy_meter_frame_receiver;

    localparam int FRAME_LEN = emfr_pkg::DEFAULT_FRAME_LENGTH;

    typedef struct {
        logic [1:0]         slot;
        logic               frame_ok;
        logic [23:0]        voltage;
        logic signed [23:0] current_a;
        logic signed [23:0] current_b;
        logic signed [23:0] power_a;
        logic signed [23:0] power_b;
    } meter_reading_t;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_slot;
    logic               m_frame_ok;
    logic [23:0]        m_voltage_raw;
    logic signed [23:0] m_current_a_raw;
    logic signed [23:0] m_current_b_raw;
    logic signed [23:0] m_power_a_raw;
    logic signed [23:0] m_power_b_raw;

    // register mirror and frame tracker
    logic [2:0]     cfg_count;
    logic [7:0]     cfg_addr [emfr_pkg::ADDR_REGS];
    logic [7:0]     frame_bytes [FRAME_LEN];
    int unsigned    frame_pos;
    logic [1:0]     frame_slot;
    meter_reading_t expected_readings [$];

    int mismatch_count;
    int bytes_accepted;
    int src_idle_pct;
    int sink_idle_pct;

    energy_meter_frame_receiver u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_slot          (m_slot),
        .m_frame_ok      (m_frame_ok),
        .m_voltage_raw   (m_voltage_raw),
        .m_current_a_raw (m_current_a_raw),
        .m_current_b_raw (m_current_b_raw),
        .m_power_a_raw   (m_power_a_raw),
        .m_power_b_raw   (m_power_b_raw)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // random receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic track_meter_byte(input logic [7:0] b);
        int unsigned    enabled;
        logic [7:0]     sum;
        meter_reading_t r;
        if (frame_pos == 0) begin
            enabled = (cfg_count > emfr_pkg::ADDR_REGS) ? emfr_pkg::ADDR_REGS : cfg_count;
            for (int i = enabled - 1; i >= 0; i--) begin
                if (cfg_addr[i] == b) begin
                    frame_slot = i[1:0];
                    frame_pos  = 1;
                end
            end
            if (frame_pos == 1) frame_bytes[0] = b;
        end else begin
            frame_bytes[frame_pos] = b;
            frame_pos++;
            if (frame_pos == FRAME_LEN) begin
                frame_pos = 0;
                sum = emfr_pkg::CHECKSUM_SEED;
                for (int i = 0; i < FRAME_LEN - 1; i++) sum += frame_bytes[i];
                r.slot      = frame_slot;
                r.frame_ok  = (~sum == frame_bytes[FRAME_LEN - 1]);
                r.voltage   = {frame_bytes[1], frame_bytes[2], frame_bytes[3]};
                r.current_a = {frame_bytes[4], frame_bytes[5], frame_bytes[6]};
                r.current_b = {frame_bytes[7], frame_bytes[8], frame_bytes[9]};
                r.power_a   = {frame_bytes[10], frame_bytes[11], frame_bytes[12]};
                r.power_b   = {frame_bytes[13], frame_bytes[14], frame_bytes[15]};
                expected_readings.push_back(r);
            end
        end
    endtask

    task automatic check_reading();
        meter_reading_t e;
        if (expected_readings.size() == 0) begin
            if (mismatch_count < 10)
                $display("unexpected result beat: slot %0d ok %0b at %0t",
                         m_slot, m_frame_ok, $realtime);
            mismatch_count++;
        end else begin
            e = expected_readings.pop_front();
            if (m_slot !== e.slot || m_frame_ok !== e.frame_ok ||
                m_voltage_raw !== e.voltage || m_current_a_raw !== e.current_a ||
                m_current_b_raw !== e.current_b || m_power_a_raw !== e.power_a ||
                m_power_b_raw !== e.power_b) begin
                if (mismatch_count < 10) begin
                    $display("result mismatch at %0t (expected / actual):", $realtime);
                    $display("  slot %0d / %0d  ok %0b / %0b  voltage %h / %h",
                             e.slot, m_slot, e.frame_ok, m_frame_ok,
                             e.voltage, m_voltage_raw);
                    $display("  current_a %h / %h  current_b %h / %h",
                             e.current_a, m_current_a_raw, e.current_b, m_current_b_raw);
                    $display("  power_a %h / %h  power_b %h / %h",
                             e.power_a, m_power_a_raw, e.power_b, m_power_b_raw);
                end
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) track_meter_byte(s_rx_byte);
            if (m_valid && m_ready) check_reading();
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_accepted++;
    endtask

    // drop valid and hold until every expected beat has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic apb_write(input emfr_pkg::reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            emfr_pkg::REG_ADDRESS_COUNT:    cfg_count   = value[2:0];
            emfr_pkg::REG_DEVICE_ADDRESS_0: cfg_addr[0] = value[7:0];
            emfr_pkg::REG_DEVICE_ADDRESS_1: cfg_addr[1] = value[7:0];
            emfr_pkg::REG_DEVICE_ADDRESS_2: cfg_addr[2] = value[7:0];
            emfr_pkg::REG_DEVICE_ADDRESS_3: cfg_addr[3] = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [2:0] count, input logic [7:0] a0,
                              input logic [7:0] a1, input logic [7:0] a2,
                              input logic [7:0] a3);
        wait_idle();
        apb_write(emfr_pkg::REG_DEVICE_ADDRESS_0, {24'($urandom_range(0, 16777215)), a0});
        apb_write(emfr_pkg::REG_DEVICE_ADDRESS_1, {24'($urandom_range(0, 16777215)), a1});
        apb_write(emfr_pkg::REG_DEVICE_ADDRESS_2, {24'($urandom_range(0, 16777215)), a2});
        apb_write(emfr_pkg::REG_DEVICE_ADDRESS_3, {24'($urandom_range(0, 16777215)), a3});
        apb_write(emfr_pkg::REG_ADDRESS_COUNT,
                  {24'($urandom_range(0, 16777215)), 5'd0, count});
    endtask

    function automatic logic [119:0] random_fields();
        logic [119:0] f;
        for (int k = 0; k < 15; k++) f[8*k +: 8] = 8'($urandom_range(0, 255));
        return f;
    endfunction

    task automatic build_frame(input logic [7:0] lead, input logic [119:0] fields,
                               input bit good, output logic [7:0] fb [FRAME_LEN]);
        logic [7:0] sum;
        fb[0] = lead;
        for (int i = 1; i < FRAME_LEN - 1; i++)
            fb[i] = (i <= 15) ? fields[119 - 8*(i-1) -: 8] : 8'($urandom_range(0, 255));
        sum = emfr_pkg::CHECKSUM_SEED;
        for (int i = 0; i < FRAME_LEN - 1; i++) sum += fb[i];
        fb[FRAME_LEN - 1] = good ? ~sum : ~sum ^ 8'($urandom_range(1, 255));
    endtask

    task automatic send_frame(input logic [7:0] lead, input logic [119:0] fields,
                              input bit good);
        logic [7:0] fb [FRAME_LEN];
        build_frame(lead, fields, good, fb);
        for (int i = 0; i < FRAME_LEN; i++) send_byte(fb[i]);
    endtask

    task automatic test_disabled_addresses();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
    endtask

    task automatic test_reading_extremes();
        set_config(3'd2, 8'h00, 8'hFF, 8'h12, 8'h34);
        send_frame(8'h00, '0, 1'b1);
        send_frame(8'hFF, {24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000001},
                   1'b1);
        send_frame(8'h00, {24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF},
                   1'b1);
    endtask

    task automatic test_bad_checksum();
        send_frame(8'hFF, random_fields(), 1'b0);
    endtask

    task automatic test_slot_priority();
        set_config(3'd4, 8'h5A, 8'h5A, 8'h5A, 8'h5A);
        send_frame(8'h5A, random_fields(), 1'b1);
        // counts above the number of registers clamp to all four
        set_config(3'd7, 8'h01, 8'h02, 8'h03, 8'hA5);
        send_frame(8'hA5, random_fields(), 1'b1);
    endtask

    task automatic test_config_mid_frame();
        logic [7:0] fb [FRAME_LEN];
        set_config(3'd2, 8'h3C, 8'hC3, 8'h00, 8'h00);
        build_frame(8'hC3, random_fields(), 1'b1, fb);
        for (int i = 0; i < FRAME_LEN / 2; i++) send_byte(fb[i]);
        wait_idle();
        apb_write(emfr_pkg::REG_DEVICE_ADDRESS_1, 32'h0000_0011);
        apb_write(emfr_pkg::REG_ADDRESS_COUNT, 32'h0000_0000);
        for (int i = FRAME_LEN / 2; i < FRAME_LEN; i++) send_byte(fb[i]);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int budget);
        int target;
        int pick;
        int enabled;
        logic [7:0] lead;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int round = 0; round < 2; round++) begin
            set_config(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
            enabled = (cfg_count > emfr_pkg::ADDR_REGS) ? emfr_pkg::ADDR_REGS : cfg_count;
            target  = bytes_accepted + budget / 2;
            while (bytes_accepted < target) begin
                pick = $urandom_range(0, 99);
                lead = cfg_addr[$urandom_range(0, enabled - 1)];
                if (pick < 80) begin
                    send_frame(lead, random_fields(), $urandom_range(0, 99) < 85);
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end else begin
                    send_byte(lead);
                    repeat ($urandom_range(1, FRAME_LEN - 2))
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        s_valid        <= 1'b0;
        s_rx_byte      <= '0;
        cfg_count      = '0;
        for (int i = 0; i < emfr_pkg::ADDR_REGS; i++) cfg_addr[i] = '0;
        frame_pos      = 0;
        frame_slot     = '0;
        mismatch_count = 0;
        bytes_accepted = 0;
        src_idle_pct   = 17;
        sink_idle_pct  = 47;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_addresses();
        test_reading_extremes();
        test_bad_checksum();
        test_slot_priority();
        test_config_mid_frame();
        test_random_traffic(17, 47, 400);
        test_random_traffic(47, 17, 400);
        test_random_traffic(0, 0, 400);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/emfr_pkg.sv
sv/emfr_unload.sv
sv/energy_meter_frame_receiver.sv
test/tb_energy_meter_frame_receiver.sv
